### rtl/core/pmt_pkg.sv
// Shared types and constants for the program map section parser.
package pmt_pkg;

  // Kind of report handed from the front end to the output stage.
  typedef enum logic [2:0] {
    KindHeader     = 3'd0,
    KindProgDesc   = 3'd1,
    KindProgByte   = 3'd2,
    KindStream     = 3'd3,
    KindStreamDesc = 3'd4,
    KindStreamByte = 3'd5,
    KindEnd        = 3'd6
  } report_kind_e;

  // One report as it travels through the queue.
  typedef struct packed {
    report_kind_e kind;
    logic [7:0]   tag_or_type;
    logic [12:0]  pid_value;
    logic [11:0]  length_value;
    logic [7:0]   data_value;
    logic [5:0]   entry_index;
  } report_t;

  // Queue between the parser front end and the output stage.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Width of the packed output data word.
  localparam int unsigned OutDataW = 48;

  // Largest byte position; the position counter holds there.
  localparam logic [11:0] PosMax = 12'hFFF;

endpackage

### rtl/core/pmt_front.sv
// Parser front end: walks the section bytes and classifies them into reports.
module pmt_front import pmt_pkg::*; #(
  parameter int unsigned MAX_PROGRAM_DESC = 16,
  parameter int unsigned MAX_STREAMS      = 32,
  parameter int unsigned MAX_STREAM_DESC  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,     // a byte request is taken this cycle
  input  logic [7:0] byte_i,
  input  logic       start_i,
  output logic       rep_valid_o,
  output report_t    rep_o
);

  typedef enum logic [3:0] {
    PhIdle, PhHdr, PhPdTag, PhPdLen, PhPdData, PhPdSkip,
    PhEsType, PhEsPidHi, PhEsPidLo, PhEsLenHi, PhEsLenLo,
    PhEdTag, PhEdLen, PhEdData, PhEdSkip, PhDone
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [11:0] pos_q, pos_d;
  logic [11:0] sec_len_q, sec_len_d;
  logic [11:0] loop_end_q, loop_end_d;
  logic [11:0] remain_q, remain_d;
  logic [12:0] pid_q, pid_d;
  logic [7:0]  held_q, held_d;
  logic [5:0]  pd_cnt_q, pd_cnt_d;
  logic [5:0]  st_cnt_q, st_cnt_d;
  logic [5:0]  sd_cnt_q, sd_cnt_d;

  function automatic logic [11:0] min12(input logic [11:0] a, input logic [11:0] b);
    min12 = (a < b) ? a : b;
  endfunction

  // Next-state and report logic for one byte.
  always_comb begin
    logic [11:0] p;
    logic [11:0] send;
    logic [11:0] len;
    logic [11:0] pil;
    logic [12:0] sum;
    logic        prog;
    phase_d     = phase_q;
    pos_d       = pos_q;
    sec_len_d   = sec_len_q;
    loop_end_d  = loop_end_q;
    remain_d    = remain_q;
    pid_d       = pid_q;
    held_d      = held_q;
    pd_cnt_d    = pd_cnt_q;
    st_cnt_d    = st_cnt_q;
    sd_cnt_d    = sd_cnt_q;
    rep_valid_o = 1'b0;
    rep_o       = '0;
    p           = '0;
    send        = '0;
    len         = '0;
    pil         = '0;
    sum         = '0;
    prog        = 1'b0;

    if (fire_i) begin
      // A start flag drops whatever section was in progress.
      if (start_i) begin
        phase_d    = PhHdr;
        pos_d      = '0;
        sec_len_d  = '0;
        loop_end_d = '0;
        remain_d   = '0;
        pid_d      = '0;
        held_d     = '0;
        pd_cnt_d   = '0;
        st_cnt_d   = '0;
        sd_cnt_d   = '0;
      end

      if (phase_d != PhIdle && phase_d != PhDone) begin
        p = pos_d;
        if (pos_d != PosMax) begin
          pos_d = pos_d + 12'd1;
        end
        send = (sec_len_d != 12'd0) ? sec_len_d - 12'd1 : 12'd0;

        if (phase_d == PhHdr) begin
          // Fixed header fields, picked out by position.
          case (p)
            12'd1:  sec_len_d = {byte_i[3:0], 8'h00};
            12'd2:  sec_len_d = {sec_len_d[11:8], byte_i};
            12'd8:  pid_d = {byte_i[4:0], 8'h00};
            12'd9:  pid_d = {pid_d[12:8], byte_i};
            12'd10: remain_d = {byte_i[3:0], 8'h00};
            12'd11: begin
              pil         = {remain_d[11:8], byte_i};
              sum         = 13'd12 + {1'b0, pil};
              loop_end_d  = (sum < {1'b0, send}) ? sum[11:0] : send;
              phase_d     = PhPdTag;
              rep_valid_o = 1'b1;
              rep_o.kind  = KindHeader;
              rep_o.pid_value    = pid_d;
              rep_o.length_value = pil;
            end
            default: ;
          endcase
        end else begin
          prog = (phase_d inside {[PhPdTag:PhPdSkip]});
          if (prog && p >= loop_end_d) begin
            phase_d = PhEsType;
            prog    = 1'b0;
          end

          if (prog) begin
            // Program descriptor loop.
            case (phase_d)
              PhPdTag: begin
                if (pd_cnt_d >= 6'(MAX_PROGRAM_DESC)) begin
                  phase_d = PhPdSkip;
                end else begin
                  held_d  = byte_i;
                  phase_d = PhPdLen;
                end
              end
              PhPdLen: begin
                len         = min12({4'h0, byte_i}, loop_end_d - p - 12'd1);
                remain_d    = len;
                rep_valid_o = 1'b1;
                rep_o.kind  = KindProgDesc;
                rep_o.tag_or_type  = held_d;
                rep_o.length_value = len;
                rep_o.entry_index  = pd_cnt_d;
                pd_cnt_d    = pd_cnt_d + 6'd1;
                phase_d     = (len == 12'd0) ? PhPdTag : PhPdData;
              end
              PhPdData: begin
                rep_valid_o = 1'b1;
                rep_o.kind  = KindProgByte;
                rep_o.tag_or_type = held_d;
                rep_o.data_value  = byte_i;
                rep_o.entry_index = pd_cnt_d - 6'd1;
                remain_d    = remain_d - 12'd1;
                if (remain_d == 12'd0) begin
                  phase_d = PhPdTag;
                end
              end
              default: ;
            endcase
          end else if (p >= send) begin
            // First CRC byte closes the section with the count report.
            phase_d     = PhDone;
            rep_valid_o = 1'b1;
            rep_o.kind  = KindEnd;
            rep_o.length_value = {6'h00, pd_cnt_d};
            rep_o.entry_index  = st_cnt_d;
          end else begin
            if ((phase_d inside {[PhEdTag:PhEdSkip]}) && p >= loop_end_d) begin
              phase_d = PhEsType;
            end
            // Elementary stream loop and its descriptors.
            case (phase_d)
              PhEsType: begin
                if (st_cnt_d >= 6'(MAX_STREAMS)) begin
                  phase_d    = PhEdSkip;
                  loop_end_d = send;
                end else begin
                  held_d  = byte_i;
                  phase_d = PhEsPidHi;
                end
              end
              PhEsPidHi: begin
                pid_d   = {byte_i[4:0], 8'h00};
                phase_d = PhEsPidLo;
              end
              PhEsPidLo: begin
                pid_d   = {pid_d[12:8], byte_i};
                phase_d = PhEsLenHi;
              end
              PhEsLenHi: begin
                remain_d = {byte_i[3:0], 8'h00};
                phase_d  = PhEsLenLo;
              end
              PhEsLenLo: begin
                len         = min12({remain_d[11:8], byte_i}, send - p - 12'd1);
                loop_end_d  = p + 12'd1 + len;
                sd_cnt_d    = '0;
                rep_valid_o = 1'b1;
                rep_o.kind  = KindStream;
                rep_o.tag_or_type  = held_d;
                rep_o.pid_value    = pid_d;
                rep_o.length_value = len;
                rep_o.entry_index  = st_cnt_d;
                st_cnt_d    = st_cnt_d + 6'd1;
                phase_d     = (len == 12'd0) ? PhEsType : PhEdTag;
              end
              PhEdTag: begin
                if (sd_cnt_d >= 6'(MAX_STREAM_DESC)) begin
                  phase_d = PhEdSkip;
                end else begin
                  held_d  = byte_i;
                  phase_d = PhEdLen;
                end
              end
              PhEdLen: begin
                len         = min12({4'h0, byte_i}, loop_end_d - p - 12'd1);
                remain_d    = len;
                rep_valid_o = 1'b1;
                rep_o.kind  = KindStreamDesc;
                rep_o.tag_or_type  = held_d;
                rep_o.length_value = len;
                rep_o.entry_index  = sd_cnt_d;
                sd_cnt_d    = sd_cnt_d + 6'd1;
                phase_d     = (len == 12'd0) ? PhEdTag : PhEdData;
              end
              PhEdData: begin
                rep_valid_o = 1'b1;
                rep_o.kind  = KindStreamByte;
                rep_o.tag_or_type = held_d;
                rep_o.data_value  = byte_i;
                rep_o.entry_index = sd_cnt_d - 6'd1;
                remain_d    = remain_d - 12'd1;
                if (remain_d == 12'd0) begin
                  phase_d = PhEdTag;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      pos_q      <= '0;
      sec_len_q  <= '0;
      loop_end_q <= '0;
      remain_q   <= '0;
      pid_q      <= '0;
      held_q     <= '0;
      pd_cnt_q   <= '0;
      st_cnt_q   <= '0;
      sd_cnt_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      sec_len_q  <= sec_len_d;
      loop_end_q <= loop_end_d;
      remain_q   <= remain_d;
      pid_q      <= pid_d;
      held_q     <= held_d;
      pd_cnt_q   <= pd_cnt_d;
      st_cnt_q   <= st_cnt_d;
      sd_cnt_q   <= sd_cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // A start byte is table_id at position zero, so the next byte is position one.
  a_start_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && start_i) |=> (pos_q == 12'd1 && phase_q == PhHdr))
    else $error("start byte did not restart the header");
  // The count report always closes the section.
  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_valid_o && rep_o.kind == KindEnd) |=> (phase_q == PhDone))
    else $error("end report without finishing the section");
  // A finished section reports nothing until the next start.
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone && !start_i) |-> !rep_valid_o)
    else $error("report after the section finished");
`endif

endmodule

### rtl/core/pmt_queue.sv
// Short report queue that decouples the parser from the output stage.
module pmt_queue import pmt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  report_t wdata_i,
  input  logic    pop_i,
  output report_t rdata_o,
  output logic    full_o,
  output logic    empty_o
);

  report_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   count_q;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage for queued reports.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("report queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("report queue underflow");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + QCntW'(1)))
    else $error("report queue count lost a push");
`endif

endmodule

### rtl/core/pmt_back.sv
// Output stage: takes reports from the queue and holds them on the master side.
module pmt_back import pmt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  report_t             head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [2:0]          m_axis_tuser
);

  logic                valid_q, valid_d;
  logic [OutDataW-1:0] data_q;
  logic [2:0]          kind_q;

  // Refill the output register whenever it is free or being taken.
  assign pop_o   = !empty_i && (!valid_q || m_axis_tready);
  assign valid_d = pop_o ? 1'b1 : (m_axis_tready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload packing, first field in the lowest bits.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= {1'b0, head_i.entry_index, head_i.data_value, head_i.length_value,
                 head_i.pid_value, head_i.tag_or_type};
      kind_q <= head_i.kind;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;

endmodule

### rtl/core/pmt_section_parser.sv
// Top level of the program map section parser.
// A report passes through the queue memory and then the output register before it reaches the master side.
// Throughput: one section byte per cycle while the report queue has room; the parser state is updated per byte.
// A four-entry report queue lets the output side stall without stopping input at once.
// Reset is asynchronous and active low; it returns the parser to idle and empties the queue.
// After reset, bytes are ignored until one arrives with the start flag set.
module pmt_section_parser import pmt_pkg::*; #(
  parameter int unsigned MAX_PROGRAM_DESC = 16,
  parameter int unsigned MAX_STREAMS      = 32,
  parameter int unsigned MAX_STREAM_DESC  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] section_byte
  input  logic                s_axis_tuser,  // [0] section_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] tag_or_type, [20:8] pid_value, [32:21] length_value,
  // [40:33] data_value, [46:41] entry_index, [47] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic [2:0]          m_axis_tuser   // [2:0] report_kind
);

  logic    fire;
  logic    rep_valid;
  report_t rep;
  report_t head;
  logic    q_full, q_empty, q_pop;

  // A byte request is taken whenever the queue has room for its report.
  assign s_axis_tready = !q_full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  pmt_front #(
    .MAX_PROGRAM_DESC (MAX_PROGRAM_DESC),
    .MAX_STREAMS      (MAX_STREAMS),
    .MAX_STREAM_DESC  (MAX_STREAM_DESC)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (s_axis_tdata),
    .start_i     (s_axis_tuser),
    .rep_valid_o (rep_valid),
    .rep_o       (rep)
  );

  pmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rep_valid),
    .wdata_i (rep),
    .pop_i   (q_pop),
    .rdata_o (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pmt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
